// ----- design/pip_pkg.sv -----
package pip_pkg;

   // request opcodes
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // result codes
   localparam logic [1:0] POS_OUTSIDE = 2'd0;
   localparam logic [1:0] POS_INSIDE  = 2'd1;
   localparam logic [1:0] POS_BORDER  = 2'd2;

   // smallest polygon the walker will accept
   localparam int MIN_VERTICES = 3;

   typedef struct packed {
      logic full;
      logic empty;
   } pip_fifo_stat_type;

endpackage

// ----- design/pip_fifo.sv -----
module pip_fifo import pip_pkg::*; #(
   parameter int WIDTH     = 40,
   parameter int DEPTH_LOG = 2
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  logic [WIDTH-1:0]    push_data,
   input  logic                pop,
   output logic [WIDTH-1:0]    pop_data,
   output pip_fifo_stat_type   stat
);

   localparam int DEPTH = 1 << DEPTH_LOG;

   logic [WIDTH-1:0]     entry_ff [DEPTH];
   logic [DEPTH_LOG-1:0] wr_ptr_ff, wr_ptr_in;
   logic [DEPTH_LOG-1:0] rd_ptr_ff, rd_ptr_in;
   logic [DEPTH_LOG:0]   cnt_ff, cnt_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data   = entry_ff[rd_ptr_ff];
   assign stat.full  = (cnt_ff == (DEPTH_LOG+1)'(DEPTH));
   assign stat.empty = (cnt_ff == '0);

endmodule

// ----- design/pip_front.sv -----
module pip_front import pip_pkg::*; #(
   parameter int MAX_VERTICES = 64,
   parameter int COORD_BITS   = 16,
   parameter int IDX_W        = 6,
   parameter int CNT_W        = 7,
   parameter int ENTRY_W      = 39
) (
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_op,
   input  logic [IDX_W-1:0]       req_vertex_index,
   input  logic [COORD_BITS-1:0]  req_coord_x,
   input  logic [COORD_BITS-1:0]  req_coord_y,
   input  pip_fifo_stat_type      fifo_stat,
   output logic                   push,
   output logic [ENTRY_W-1:0]     push_data
);

   logic idx_in_range;
   logic keep;

   // loads past the end of the store are taken and dropped
   assign idx_in_range = ({1'b0, req_vertex_index} < CNT_W'(MAX_VERTICES));
   assign keep         = (req_op == OP_QUERY) || idx_in_range;

   assign req_ready = !fifo_stat.full;
   assign push      = req_valid && req_ready && keep;
   assign push_data = {req_op, req_vertex_index, req_coord_x, req_coord_y};

endmodule

// ----- design/pip_back.sv -----
module pip_back import pip_pkg::*; #(
   parameter int MAX_VERTICES = 64,
   parameter int COORD_BITS   = 16,
   parameter int IDX_W        = 6,
   parameter int CNT_W        = 7,
   parameter int ENTRY_W      = 39
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [CNT_W-1:0]     csr_wr_data,
   input  pip_fifo_stat_type    fifo_stat,
   input  logic [ENTRY_W-1:0]   pop_data,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [1:0]           rsp_position
);

   localparam int CB   = COORD_BITS;
   localparam int PW   = 2*CB + 2;
   localparam int CW   = 2*CB + 3;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_WAIT = 2'd2;

   // storage
   logic [CB-1:0] mem_x [MAX_VERTICES];
   logic [CB-1:0] mem_y [MAX_VERTICES];

   logic [CNT_W-1:0] vertex_count_ff;
   logic [CNT_W-1:0] n_ff, n_in;
   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] issue_cnt_ff, issue_cnt_in;

   // queue head
   logic                 ent_op;
   logic [IDX_W-1:0]     ent_idx;
   logic signed [CB-1:0] ent_x, ent_y;
   logic                 start_query, do_load;

   // point under test
   logic signed [CB-1:0] px_ff, py_ff;

   // read stage
   logic                 issue_vld, issue_close, rd_en;
   logic                 vert_vld_ff, vert_first_ff, vert_close_ff;
   logic signed [CB-1:0] vert_x_ff, vert_y_ff;
   logic signed [CB-1:0] first_x_ff, first_y_ff, prev_x_ff, prev_y_ff;

   // edge stage
   logic signed [CB-1:0] ax, ay, bx, by;
   logic signed [CB:0]   dx_ba, dy_ba, dx_pa, dy_pa;
   logic                 edge_vld, inbox, hrange, dir;
   logic                 e_vld_ff, e_last_ff, e_inbox_ff, e_hrange_ff, e_dir_ff;
   logic signed [PW-1:0] prod_a_ff, prod_b_ff;

   // accumulate stage
   logic signed [CW-1:0] cross_c;
   logic                 hit, crosses;
   logic                 border_ff, border_in, parity_ff, parity_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [1:0]           rsp_pos_ff;

   assign ent_op  = pop_data[ENTRY_W-1];
   assign ent_idx = pop_data[2*CB +: IDX_W];
   assign ent_x   = pop_data[CB +: CB];
   assign ent_y   = pop_data[0 +: CB];

   // a query may only start once the previous result has left
   assign pop = (state_ff == ST_IDLE) && !fifo_stat.empty
                && ((ent_op == OP_LOAD) || !rsp_valid_ff);
   assign start_query = pop && (ent_op == OP_QUERY);
   assign do_load     = pop && (ent_op == OP_LOAD);

   always_comb begin
      n_in = vertex_count_ff;
      if (vertex_count_ff < CNT_W'(MIN_VERTICES)) begin
         n_in = CNT_W'(MIN_VERTICES);
      end else if (vertex_count_ff > CNT_W'(MAX_VERTICES)) begin
         n_in = CNT_W'(MAX_VERTICES);
      end
   end

   // read sequencer: addresses 0..n-1, then one closing beat back to vertex 0
   assign issue_vld   = (state_ff == ST_RUN);
   assign issue_close = (issue_cnt_ff == n_ff);
   assign rd_en       = issue_vld && !issue_close;

   always_comb begin
      state_in     = state_ff;
      issue_cnt_in = issue_cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start_query) begin
               state_in     = ST_RUN;
               issue_cnt_in = '0;
            end
         end
         ST_RUN: begin
            issue_cnt_in = issue_cnt_ff + 1'b1;
            if (issue_close) begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (e_vld_ff && e_last_ff) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         issue_cnt_ff    <= '0;
         vertex_count_ff <= CNT_W'(MIN_VERTICES);
         vert_vld_ff     <= 1'b0;
         e_vld_ff        <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issue_cnt_ff <= issue_cnt_in;
         vert_vld_ff  <= issue_vld;
         e_vld_ff     <= edge_vld;
         if (csr_wr_en) begin
            vertex_count_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start_query) begin
         px_ff <= ent_x;
         py_ff <= ent_y;
         n_ff  <= n_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_load) begin
         mem_x[ent_idx] <= ent_x;
         mem_y[ent_idx] <= ent_y;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         vert_x_ff <= mem_x[issue_cnt_ff[IDX_W-1:0]];
         vert_y_ff <= mem_y[issue_cnt_ff[IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      vert_first_ff <= (issue_cnt_ff == '0);
      vert_close_ff <= issue_close;
   end

   // edge stage: a = previous vertex, b = current or the first on the closing beat
   assign ax = prev_x_ff;
   assign ay = prev_y_ff;
   assign bx = vert_close_ff ? first_x_ff : vert_x_ff;
   assign by = vert_close_ff ? first_y_ff : vert_y_ff;

   assign edge_vld = vert_vld_ff && !vert_first_ff;

   assign dx_ba = {bx[CB-1], bx} - {ax[CB-1], ax};
   assign dy_ba = {by[CB-1], by} - {ay[CB-1], ay};
   assign dx_pa = {px_ff[CB-1], px_ff} - {ax[CB-1], ax};
   assign dy_pa = {py_ff[CB-1], py_ff} - {ay[CB-1], ay};

   assign inbox  = ((px_ff >= ax) || (px_ff >= bx)) && ((px_ff <= ax) || (px_ff <= bx))
                   && ((py_ff >= ay) || (py_ff >= by)) && ((py_ff <= ay) || (py_ff <= by));
   assign dir    = (ay > by);
   // half-open span [lower y, upper y)
   assign hrange = dir ? ((py_ff >= by) && (py_ff < ay))
                       : ((py_ff >= ay) && (py_ff < by));

   always_ff @(posedge clock) begin
      if (vert_vld_ff && vert_first_ff) begin
         first_x_ff <= vert_x_ff;
         first_y_ff <= vert_y_ff;
      end
      if (vert_vld_ff) begin
         prev_x_ff <= vert_x_ff;
         prev_y_ff <= vert_y_ff;
      end
      e_last_ff   <= vert_close_ff;
      e_inbox_ff  <= inbox;
      e_hrange_ff <= hrange;
      e_dir_ff    <= dir;
      prod_a_ff   <= dx_ba * dy_pa;
      prod_b_ff   <= dy_ba * dx_pa;
   end

   // cross = (b-a) x (p-a); sign flips when the edge runs downward
   assign cross_c = {prod_a_ff[PW-1], prod_a_ff} - {prod_b_ff[PW-1], prod_b_ff};
   assign hit     = e_inbox_ff && (cross_c == '0);
   assign crosses = e_hrange_ff && (e_dir_ff ? (cross_c < 0) : (cross_c > 0));

   always_comb begin
      border_in    = border_ff;
      parity_in    = parity_ff;
      rsp_valid_in = rsp_valid_ff;
      if (start_query) begin
         border_in = 1'b0;
         parity_in = 1'b0;
      end else if (e_vld_ff) begin
         border_in = border_ff | hit;
         parity_in = parity_ff ^ crosses;
      end
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (e_vld_ff && e_last_ff) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         border_ff    <= 1'b0;
         parity_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         border_ff    <= border_in;
         parity_ff    <= parity_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (e_vld_ff && e_last_ff) begin
         rsp_pos_ff <= border_in ? POS_BORDER : (parity_in ? POS_INSIDE : POS_OUTSIDE);
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_position = rsp_pos_ff;

`ifndef SYNTHESIS
   a_pop_only_idle: assert property (@(posedge clock) disable iff (reset)
      pop |-> state_ff == ST_IDLE)
      else $error("queue popped while a query is running");

   a_issue_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RUN |-> issue_cnt_ff <= n_ff)
      else $error("edge counter ran past the vertex count");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      e_vld_ff && e_last_ff |-> !rsp_valid_ff)
      else $error("result finished while the previous one is still held");

   a_pos_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_pos_ff == POS_OUTSIDE || rsp_pos_ff == POS_INSIDE
                        || rsp_pos_ff == POS_BORDER))
      else $error("undefined position code");
`endif

endmodule

// ----- design/point_in_polygon_test_top.sv -----
// channel | direction | handshake            | payload
// req     | in        | req_valid/req_ready  | req_op, req_vertex_index, req_coord_x, req_coord_y
// rsp     | out       | rsp_valid/rsp_ready  | rsp_position
// csr     | in        | csr_wr_en            | csr_wr_data (vertex_count)
//
// Loads give no result. A query reads the first n vertices (n = clamped vertex count)
// at one vertex per cycle, plus a closing beat back to vertex 0. A new query starts
// only once the previous one has finished and its result has left the block.
// A four-entry queue feeds the walker; req_ready drops only when it is full, and a
// held result stalls the next query but not loads.
// Reset is synchronous, active high; the vertex memory is not cleared.
module point_in_polygon_test_top import pip_pkg::*; #(
   parameter int MAX_VERTICES = 64,
   parameter int COORD_BITS   = 16,
   localparam int IDX_W       = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1,
   localparam int CNT_W       = $clog2(MAX_VERTICES + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_op,
   input  logic [IDX_W-1:0]       req_vertex_index,
   input  logic [COORD_BITS-1:0]  req_coord_x,
   input  logic [COORD_BITS-1:0]  req_coord_y,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [1:0]             rsp_position,
   input  logic                   csr_wr_en,
   input  logic [CNT_W-1:0]       csr_wr_data
);

   localparam int ENTRY_W = 1 + IDX_W + 2*COORD_BITS;

   pip_fifo_stat_type    fifo_stat;
   logic                 push, pop;
   logic [ENTRY_W-1:0]   push_data, pop_data;

   pip_front #(
      .MAX_VERTICES (MAX_VERTICES),
      .COORD_BITS   (COORD_BITS),
      .IDX_W        (IDX_W),
      .CNT_W        (CNT_W),
      .ENTRY_W      (ENTRY_W)
   ) u_front (
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_op           (req_op),
      .req_vertex_index (req_vertex_index),
      .req_coord_x      (req_coord_x),
      .req_coord_y      (req_coord_y),
      .fifo_stat        (fifo_stat),
      .push             (push),
      .push_data        (push_data)
   );

   pip_fifo #(
      .WIDTH     (ENTRY_W),
      .DEPTH_LOG (2)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .stat      (fifo_stat)
   );

   pip_back #(
      .MAX_VERTICES (MAX_VERTICES),
      .COORD_BITS   (COORD_BITS),
      .IDX_W        (IDX_W),
      .CNT_W        (CNT_W),
      .ENTRY_W      (ENTRY_W)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .fifo_stat    (fifo_stat),
      .pop_data     (pop_data),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_position (rsp_position)
   );

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
   import pip_pkg::*;

   localparam int MAX_VERTS      = 64;
   localparam int COORD_W        = 16;
   localparam int IDX_W          = 6;
   localparam int CNT_W          = 7;
   localparam int COORD_MAX      = 32767;
   localparam int ITEMS_PER_PHASE = 90;
   localparam int NUM_PHASES     = 12;
   localparam int STALL_LIMIT    = 4000;
   // longest walk twice over, plus the intake queue
   localparam int DRAIN_CYCLES   = 2 * (MAX_VERTS + 4) + 8;

   typedef struct packed {
      logic               op;
      logic [IDX_W-1:0]   index;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
   } vertex_beat_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic               req_op = OP_LOAD;
   logic [IDX_W-1:0]   req_vertex_index = '0;
   logic [COORD_W-1:0] req_coord_x = '0;
   logic [COORD_W-1:0] req_coord_y = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [1:0]         rsp_position;
   logic               csr_wr_en = 1'b0;
   logic [CNT_W-1:0]   csr_wr_data = '0;

   point_in_polygon_test_top #(
      .MAX_VERTICES (MAX_VERTS),
      .COORD_BITS   (COORD_W)
   ) uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_op           (req_op),
      .req_vertex_index (req_vertex_index),
      .req_coord_x      (req_coord_x),
      .req_coord_y      (req_coord_y),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_position     (rsp_position),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // stimulus side
   vertex_beat_type pending_beats[$];
   longint       gen_x[MAX_VERTS];
   longint       gen_y[MAX_VERTS];
   bit           gen_written[MAX_VERTS];
   int           items_queued = 0;
   int           src_idle_pct = 0;
   int           sink_stall_pct = 0;

   // predictor side
   longint       poly_x[MAX_VERTS];
   longint       poly_y[MAX_VERTS];
   logic [CNT_W-1:0] poly_count;
   logic [1:0]   expected_pos_q[$];
   int           items_accepted = 0;
   bit           req_fire = 1'b0;
   int           idle_cycles = 0;

   int           error_count = 0;
   int           n_loads = 0;
   int           n_queries = 0;
   int           pos_seen[3] = '{0, 0, 0};

   task automatic report_mismatch(input string msg);
      error_count++;
      $display("MISMATCH @%0t: %s", $time, msg);
   endtask

   function automatic int clamp_count(input int v);
      if (v < MIN_VERTICES)
         return MIN_VERTICES;
      if (v > MAX_VERTS)
         return MAX_VERTS;
      return v;
   endfunction

   function automatic bit lies_on_edge(input longint px, py, ax, ay, bx, by);
      if ((by - ay) * (px - ax) != (bx - ax) * (py - ay))
         return 1'b0;
      if (px < (ax < bx ? ax : bx) || px > (ax > bx ? ax : bx))
         return 1'b0;
      if (py < (ay < by ? ay : by) || py > (ay > by ? ay : by))
         return 1'b0;
      return 1'b1;
   endfunction

   // half-open in y so a ray through a shared vertex counts once
   function automatic bit ray_hits_edge(input longint px, py, ax, ay, bx, by);
      longint lx, ly, ux, uy;
      if (ay > by) begin
         lx = bx; ly = by; ux = ax; uy = ay;
      end else begin
         lx = ax; ly = ay; ux = bx; uy = by;
      end
      if (py < ly || py >= uy)
         return 1'b0;
      return (py - ly) * (ux - lx) > (px - lx) * (uy - ly);
   endfunction

   function automatic logic [1:0] locate_point(input longint px, py);
      int n, i, j;
      bit odd;
      n = clamp_count(poly_count);
      odd = 1'b0;
      for (i = 0; i < n; i++) begin
         j = (i + 1 == n) ? 0 : i + 1;
         if (lies_on_edge(px, py, poly_x[i], poly_y[i], poly_x[j], poly_y[j]))
            return POS_BORDER;
         if (ray_hits_edge(px, py, poly_x[i], poly_y[i], poly_x[j], poly_y[j]))
            odd = !odd;
      end
      return odd ? POS_INSIDE : POS_OUTSIDE;
   endfunction

   function automatic longint clamp_coord(input longint v);
      if (v > COORD_MAX)
         return COORD_MAX;
      if (v < -COORD_MAX - 1)
         return -COORD_MAX - 1;
      return v;
   endfunction

   function automatic longint rand_coord(input int span);
      logic signed [COORD_W-1:0] w;
      longint v;
      if (span >= COORD_MAX) begin
         w = COORD_W'($urandom());
         return w;
      end
      v = $urandom_range(2 * span);
      return v - span;
   endfunction

   task automatic push_load(input int idx, input longint x, input longint y);
      vertex_beat_type b;
      b.op = OP_LOAD;
      b.index = IDX_W'(idx);
      b.x = x[COORD_W-1:0];
      b.y = y[COORD_W-1:0];
      gen_x[idx] = x;
      gen_y[idx] = y;
      gen_written[idx] = 1'b1;
      pending_beats.push_back(b);
      items_queued++;
   endtask

   task automatic push_query(input longint x, input longint y);
      vertex_beat_type b;
      b.op = OP_QUERY;
      b.index = IDX_W'($urandom_range(MAX_VERTS - 1));   // don't care on a query
      b.x = x[COORD_W-1:0];
      b.y = y[COORD_W-1:0];
      pending_beats.push_back(b);
      items_queued++;
   endtask

   // query points biased toward vertices, edges and vertex rows
   task automatic push_random_query(input int n, input int span);
      int i, j;
      longint px, py, off;
      i = $urandom_range(n - 1);
      j = (i + 1 == n) ? 0 : i + 1;
      case ($urandom_range(5))
         0: begin
            px = gen_x[i];
            py = gen_y[i];
         end
         1: begin
            px = (gen_x[i] + gen_x[j]) >>> 1;
            py = (gen_y[i] + gen_y[j]) >>> 1;
         end
         2: begin
            off = $urandom_range(4);
            px = clamp_coord(gen_x[i] + off - 2);
            off = $urandom_range(4);
            py = clamp_coord(gen_y[i] + off - 2);
         end
         3: begin
            px = rand_coord(span);
            py = rand_coord(span);
         end
         4: begin
            px = rand_coord(COORD_MAX);
            py = rand_coord(COORD_MAX);
         end
         default: begin
            px = rand_coord(span);
            py = gen_y[i];
         end
      endcase
      push_query(px, py);
   endtask

   task automatic wait_idle();
      do
         @(negedge clock);
      while (items_accepted != items_queued || expected_pos_q.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // driver
   always @(negedge clock) begin
      vertex_beat_type next_beat;
      if (reset) begin
         req_valid <= 1'b0;
         rsp_ready <= 1'b0;
      end else begin
         if (!req_valid || req_fire) begin
            if (pending_beats.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
               next_beat = pending_beats.pop_front();
               req_valid        <= 1'b1;
               req_op           <= next_beat.op;
               req_vertex_index <= next_beat.index;
               req_coord_x      <= next_beat.x;
               req_coord_y      <= next_beat.y;
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_ready <= ($urandom_range(99) >= sink_stall_pct);
      end
   end

   // monitor, predictor and watchdog
   always @(posedge clock) begin
      logic signed [COORD_W-1:0] sx, sy;
      logic [1:0] want;
      bit rsp_fire;
      if (reset) begin
         poly_count = CNT_W'(MIN_VERTICES);
         req_fire = 1'b0;
         idle_cycles = 0;
      end else begin
         req_fire = req_valid && req_ready;
         rsp_fire = rsp_valid && rsp_ready;
         if (rsp_fire) begin
            if (expected_pos_q.size() == 0) begin
               report_mismatch($sformatf("position %0d with no query outstanding",
                                         rsp_position));
            end else begin
               want = expected_pos_q.pop_front();
               if (rsp_position !== want)
                  report_mismatch($sformatf("position %0d, expected %0d",
                                            rsp_position, want));
               else
                  pos_seen[want]++;
            end
         end
         if (req_fire) begin
            items_accepted++;
            sx = req_coord_x;
            sy = req_coord_y;
            if (req_op == OP_LOAD) begin
               poly_x[req_vertex_index] = sx;
               poly_y[req_vertex_index] = sy;
               n_loads++;
            end else begin
               expected_pos_q.push_back(locate_point(sx, sy));
               n_queries++;
            end
         end
         if (csr_wr_en)
            poly_count = csr_wr_data;
         if (req_fire || rsp_fire ||
             (items_accepted == items_queued && expected_pos_q.size() == 0))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("Watchdog: no beat moved for %0d cycles, %0d results pending",
                     STALL_LIMIT, expected_pos_q.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   initial begin
      int phase_counts[NUM_PHASES];
      int p, i, n, span, budget, r;
      bit all_written;

      for (i = 0; i < MAX_VERTS; i++)
         gen_written[i] = 1'b0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // directed part, reset vertex count of three
      // full-scale triangle, corners at the coordinate extremes
      push_load(0, -32768, -32768);
      push_load(1, 32767, -32768);
      push_load(2, 0, 32767);
      push_load(63, 32767, 32767);
      push_query(0, 0);
      push_query(-32768, -32768);
      push_query(0, -32768);
      push_query(32767, 32767);
      push_query(-32768, 32767);
      push_query(0, 32767);
      // degenerate edge: first two vertices coincide
      push_load(0, 10, 10);
      push_load(1, 10, 10);
      push_load(2, 20, 30);
      push_query(10, 10);
      push_query(15, 20);
      // ray through a vertex and through the apex
      push_load(0, 0, -10);
      push_load(1, 10, 0);
      push_load(2, 0, 10);
      push_query(-5, 0);
      push_query(5, 0);
      push_query(-5, 10);
      // horizontal edge, ray running along it
      push_load(0, 0, 0);
      push_load(1, 100, 0);
      push_load(2, 50, 100);
      push_query(150, 0);
      push_query(-10, 0);
      wait_idle();

      phase_counts = '{4, 0, 127, 9, 3 + $urandom_range(13), 64, 2,
                       17 + $urandom_range(46), 65, 1, 3 + $urandom_range(7), 3};

      for (p = 0; p < NUM_PHASES; p++) begin
         case (p % 4)
            0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
            1: begin src_idle_pct = 75; sink_stall_pct = 0;  end
            2: begin src_idle_pct = 0;  sink_stall_pct = 75; end
            default: begin src_idle_pct = 38; sink_stall_pct = 38; end
         endcase
         csr_wr_en   <= 1'b1;
         csr_wr_data <= CNT_W'(phase_counts[p]);
         @(negedge clock);
         csr_wr_en   <= 1'b0;

         n = clamp_count(phase_counts[p]);
         case ($urandom_range(2))
            0: span = 6;
            1: span = 400;
            default: span = COORD_MAX;
         endcase
         budget = ITEMS_PER_PHASE;
         all_written = 1'b1;
         for (i = 0; i < n; i++)
            if (!gen_written[i])
               all_written = 1'b0;
         // mostly a fresh polygon; sometimes only a few corners move
         if (all_written && $urandom_range(3) == 0) begin
            r = $urandom_range(1, n);
            for (i = 0; i < r; i++)
               push_load($urandom_range(n - 1), rand_coord(span), rand_coord(span));
            budget -= r;
         end else begin
            for (i = 0; i < n; i++)
               push_load(i, rand_coord(span), rand_coord(span));
            budget -= n;
         end
         if (budget < 20)
            budget = 20;

         for (i = 0; i < budget; i++) begin
            r = $urandom_range(99);
            if (r < 8)
               push_load($urandom_range(MAX_VERTS - 1), rand_coord(COORD_MAX),
                         rand_coord(COORD_MAX));
            else if (r < 12)
               push_load($urandom_range(n - 1), rand_coord(span), rand_coord(span));
            else
               push_random_query(n, span);
         end
         wait_idle();
      end

      $display("Run covered %0d beats (%0d vertex loads, %0d queries)",
               items_accepted, n_loads, n_queries);
      $display("over %0d vertex-count settings; positions seen: %0d outside, %0d inside, %0d border",
               NUM_PHASES + 1, pos_seen[POS_OUTSIDE], pos_seen[POS_INSIDE],
               pos_seen[POS_BORDER]);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
